### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared constants, types and round functions of the sha-1 hash engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int WORD_BYTES   = 4;
  localparam int BLOCK_WORDS  = BLOCK_BYTES / WORD_BYTES;
  localparam int DIGEST_WORDS = 5;
  localparam int NUM_ROUNDS   = 80;
  localparam int POS_W        = $clog2(BLOCK_BYTES);
  localparam int WADDR_W      = $clog2(BLOCK_WORDS);
  localparam int RND_W        = $clog2(NUM_ROUNDS);
  // bit length is {block count, byte position, 3'b0}; upper count bits fall off
  localparam int BLK_CNT_W    = 64 - POS_W - 3;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ABSORB = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

  localparam digest_t INIT_WORDS = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  function automatic logic [31:0] sha1_f(input logic [RND_W-1:0] t,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    if (t < RND_W'(20)) begin
      f = (b & c) | (~b & d);
    end else if (t < RND_W'(40)) begin
      f = b ^ c ^ d;
    end else if (t < RND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] sha1_k(input logic [RND_W-1:0] t);
    logic [31:0] k;
    if (t < RND_W'(20)) begin
      k = K0;
    end else if (t < RND_W'(40)) begin
      k = K1;
    end else if (t < RND_W'(60)) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

### rtl/sha1_ram.sv
// ----------------------------------------------------------------------------
// sha1_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/sha1_out.sv
// ----------------------------------------------------------------------------
// sha1_out
// digest holding register that sends the five words out one per transfer
// ----------------------------------------------------------------------------
module sha1_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sha1_pkg::digest_t digest,
  output logic             busy,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,   // [31:0] digest_word
  output logic             out_tlast    // digest_last
);
  import sha1_pkg::*;

  localparam int CNT_W = $clog2(DIGEST_WORDS + 1);

  digest_t            words_r;
  logic [CNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(DIGEST_WORDS);
    end else if (out_tvalid && out_tready) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= digest;
    end else if (out_tvalid && out_tready) begin
      words_r <= {32'h0, words_r[DIGEST_WORDS-1:1]};
    end
  end

  assign busy       = (cnt_r != '0);
  assign out_tvalid = busy;
  assign out_tdata  = words_r[0];
  assign out_tlast  = (cnt_r == CNT_W'(1));

endmodule

### rtl/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine
// sha-1 engine on a byte stream with a block buffer ram and one round per cycle
// ----------------------------------------------------------------------------
// input channel: in_tuser carries the command (start, absorb byte, finish),
// in_tdata the message byte. output channel: five digest words h0..h4, the
// fifth marked by out_tlast.
// a start or a byte that does not complete a block leaves in_tready high; the
// byte that completes a 64-byte block starts a compression (a ram prime state,
// the rounds, a chaining add) during which in_tready is low;
// rounds run one per cycle through a single round unit fed from the block
// ram and a 16-word schedule shift line.
// finish runs the same compression, twice when the padding spills into a second
// block, then hands the digest to the output register; the engine is then
// ready for a new message while the digest words still go out.
// a stalled receiver holds the digest; a further finish waits for the output
// register to empty before its handoff.
// reset loads the initial chaining words and clears the length; the block
// ram needs no clearing.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_ROUND,
    ST_ADD,
    ST_HAND
  } state_t;

  state_t               state_r;
  logic [RND_W-1:0]     rnd_r;
  logic [POS_W-1:0]     pos_r;
  logic [BLK_CNT_W-1:0] blk_r;
  logic                 pad_r;
  logic                 phase_r;
  digest_t              chain_r;

  logic [31:0]          a_r, b_r, c_r, d_r, e_r;
  logic [31:0]          w_r [BLOCK_WORDS];
  logic [23:0]          word_r;

  logic                 in_xfer;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [31:0]          ram_rdata;
  logic [31:0]          pad_word;
  logic [31:0]          w_src;
  logic [31:0]          w_exp;
  logic [31:0]          w_cur;
  logic [31:0]          tmp;
  logic [63:0]          bit_len;
  logic [WADDR_W-1:0]   t_idx;
  logic [WADDR_W-1:0]   pidx;
  logic                 two_blocks;
  logic                 out_busy;
  logic                 out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign ram_we    = in_xfer && (in_tuser == CMD_ABSORB) && (pos_r[1:0] == 2'b11);
  assign ram_raddr = (state_r == ST_ROUND) ? (rnd_r[WADDR_W-1:0] + WADDR_W'(1))
                                           : '0;

  sha1_ram #(
    .WIDTH (32),
    .DEPTH (BLOCK_WORDS)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pos_r[POS_W-1:2]),
    .wr_data ({word_r, in_tdata}),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // message word source for the first sixteen rounds, with padding
  assign bit_len    = {blk_r, pos_r, 3'b000};
  assign t_idx      = rnd_r[WADDR_W-1:0];
  assign pidx       = pos_r[POS_W-1:2];
  assign two_blocks = (pos_r[POS_W-1:3] == '1);

  always_comb begin
    case (pos_r[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {word_r[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {word_r[15:0], PAD_BYTE, 8'h0};
      2'd3:    pad_word = {word_r, PAD_BYTE};
      default: pad_word = '0;
    endcase
  end

  always_comb begin
    w_src = '0;
    if (!pad_r) begin
      w_src = ram_rdata;
    end else if (!phase_r && (t_idx < pidx)) begin
      w_src = ram_rdata;
    end else if (!phase_r && (t_idx == pidx)) begin
      w_src = pad_word;
    end else if (phase_r || !two_blocks) begin
      if (t_idx == WADDR_W'(BLOCK_WORDS - 2)) begin
        w_src = bit_len[63:32];
      end else if (t_idx == WADDR_W'(BLOCK_WORDS - 1)) begin
        w_src = bit_len[31:0];
      end
    end
  end

  // rolling schedule: w_r[15] is w[t-1]
  assign w_exp = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_cur = (rnd_r < RND_W'(BLOCK_WORDS)) ? w_src : {w_exp[30:0], w_exp[31]};
  assign tmp   = {a_r[26:0], a_r[31:27]} + sha1_f(rnd_r, b_r, c_r, d_r) + e_r
               + sha1_k(rnd_r) + w_cur;

  assign out_load = (state_r == ST_HAND) && !out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      pos_r   <= '0;
      blk_r   <= '0;
      pad_r   <= 1'b0;
      phase_r <= 1'b0;
      chain_r <= INIT_WORDS;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_tuser)
              CMD_START: begin
                chain_r <= INIT_WORDS;
                blk_r   <= '0;
                pos_r   <= '0;
              end
              CMD_ABSORB: begin
                pos_r <= pos_r + POS_W'(1);
                if (pos_r == '1) begin
                  pad_r   <= 1'b0;
                  state_r <= ST_PRIME;
                end
              end
              CMD_FINISH: begin
                pad_r   <= 1'b1;
                phase_r <= 1'b0;
                state_r <= ST_PRIME;
              end
              default: ;
            endcase
          end
        end
        ST_PRIME: begin
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + RND_W'(1);
          if (rnd_r == RND_W'(NUM_ROUNDS - 1)) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          if (!pad_r) begin
            blk_r   <= blk_r + BLK_CNT_W'(1);
            state_r <= ST_IDLE;
          end else if (!phase_r && two_blocks) begin
            phase_r <= 1'b1;
            state_r <= ST_PRIME;
          end else begin
            state_r <= ST_HAND;
          end
        end
        ST_HAND: begin
          if (!out_busy) begin
            chain_r <= INIT_WORDS;
            blk_r   <= '0;
            pos_r   <= '0;
            pad_r   <= 1'b0;
            phase_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_tuser == CMD_ABSORB)) begin
      word_r <= {word_r[15:0], in_tdata};
    end
    if (state_r == ST_PRIME) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (state_r == ST_ROUND) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLOCK_WORDS-1] <= w_cur;
    end
  end

  sha1_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .digest     (chain_r),
    .busy       (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks of the sha-1 hash engine, bound to the top level
// ----------------------------------------------------------------------------
module sha1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);
  import sha1_pkg::*;

  // no digest word right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // a finish always starts a compression
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_FINISH) |=> !in_tready)
    else $error("engine ready right after finish");

  // digest words follow back to back until the last one
  a_digest_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("digest run broken before last word");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/tb_sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// tb_sha1_hash_engine
// self-checking bench for the sha-1 engine on a byte stream
// ----------------------------------------------------------------------------
// commands and message bytes go in over the input stream with random gaps; a
// tracker class hashes the same commands in step and holds the digest words
// each finish should produce. every word on the output stream is matched
// against the oldest one held. a directed opener covers unstarted messages,
// empty messages, restarts, the unused command and back-to-back finishes.
// longer messages follow, at lengths around the padding spill point and
// across a block border. the receiver once holds off long enough that the
// engine stalls its input.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;
  import sha1_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_GAP     = 11;
  localparam int LONG_HOLD   = 1000;
  localparam int END_CYCLES  = 200;
  localparam int MIN_ITEMS   = 200;
  localparam int MIN_DIGESTS = 12;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  class sha1_digest_tracker;
    logic [31:0]  hash_state [DIGEST_WORDS];
    logic [7:0]   msg_block [BLOCK_BYTES];
    int           fill;
    logic [63:0]  blocks_done;
    digest_beat_t digest_due [$];
    int           mismatches;

    function new();
      mismatches = 0;
      restart_message();
    endfunction

    function void restart_message();
      for (int i = 0; i < DIGEST_WORDS; i++) hash_state[i] = INIT_WORDS[i];
      fill = 0;
      blocks_done = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void run_rounds();
      logic [31:0] sched [BLOCK_WORDS];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int t = 0; t < BLOCK_WORDS; t++) begin
        sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int t = 0; t < NUM_ROUNDS; t++) begin
        if (t >= 16) begin
          sched[t % 16] = rotl(sched[(t - 3) % 16] ^ sched[(t - 8) % 16] ^
                               sched[(t - 14) % 16] ^ sched[t % 16], 1);
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        tmp = rotl(a, 5) + f + e + k + sched[t % 16];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = tmp;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
    endfunction

    function void take_command(logic [1:0] cmd, logic [7:0] data);
      logic [63:0] bit_len;
      case (cmd)
        CMD_START: restart_message();
        CMD_ABSORB: begin
          msg_block[fill] = data;
          fill++;
          if (fill == BLOCK_BYTES) begin
            run_rounds();
            blocks_done++;
            fill = 0;
          end
        end
        CMD_FINISH: begin
          bit_len = (blocks_done << 9) + (64'(fill) << 3);
          msg_block[fill] = PAD_BYTE;
          for (int i = fill + 1; i < BLOCK_BYTES; i++) msg_block[i] = 8'h00;
          // no room left for the length field
          if (fill >= BLOCK_BYTES - 8) begin
            run_rounds();
            for (int i = 0; i < BLOCK_BYTES - 8; i++) msg_block[i] = 8'h00;
          end
          for (int i = 0; i < 8; i++) msg_block[BLOCK_BYTES - 8 + i] = bit_len[63 - 8*i -: 8];
          run_rounds();
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            digest_due.push_back(digest_beat_t'{word: hash_state[i],
                                                last: (i == DIGEST_WORDS - 1)});
          end
          restart_message();
        end
        default: ;
      endcase
    endfunction

    function void match_digest_word(logic [31:0] word, logic last);
      digest_beat_t due;
      if (digest_due.size() == 0) begin
        $error("digest_word: expected none, actual %h", word);
        mismatches++;
        return;
      end
      due = digest_due.pop_front();
      if (word !== due.word) begin
        $error("digest_word: expected %h, actual %h", due.word, word);
        mismatches++;
      end
      if (last !== due.last) begin
        $error("digest_last: expected %0b, actual %0b", due.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return digest_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  sha1_digest_tracker tracker;
  int items_sent;
  int digests_asked;
  int hold_requests;
  int cycle_count;
  bit src_burst;

  sha1_hash_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return $urandom_range(0, 16);
    if (r <= 7) return $urandom_range(52, 70);
    if (r == 8) return $urandom_range(100, 130);
    return $urandom_range(0, 4);
  endfunction

  task send_command(logic [1:0] cmd, logic [7:0] data);
    int gap;
    gap = pick_gap(src_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    tracker.take_command(cmd, data);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_FINISH) digests_asked++;
  endtask

  task send_bytes(int count, bit noisy);
    for (int i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_command(CMD_UNUSED, rand_byte());
      // restart in the middle of a message
      if (noisy && $urandom_range(0, 39) == 0) send_command(CMD_START, rand_byte());
      send_command(CMD_ABSORB, rand_byte());
    end
  endtask

  task send_message(int len);
    if ($urandom_range(0, 7) != 0) send_command(CMD_START, rand_byte());
    send_bytes(len, 1'b1);
    send_command(CMD_FINISH, rand_byte());
    if ($urandom_range(0, 9) == 0) send_command(CMD_UNUSED, rand_byte());
  endtask

  task wait_digests_out();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // result side
  initial begin
    int sink_wait;
    int holds_served;
    bit sink_burst;
    sink_wait = 0;
    holds_served = 0;
    sink_burst = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        tracker.match_digest_word(out_tdata, out_tlast);
        sink_wait = pick_gap(sink_burst);
        if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
      end
      if (hold_requests != holds_served) begin
        sink_wait = LONG_HOLD;
        holds_served = hold_requests;
      end
      if (sink_wait > 0) begin
        out_tready <= 1'b0;
        sink_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha1_hash_engine test failed");
    $finish;
  end

  initial begin
    int boundary_lengths [6];
    int msg;
    boundary_lengths = '{56, 63, 64, 55, 119, 120};
    tracker = new();
    items_sent = 0;
    digests_asked = 0;
    hold_requests = 0;
    src_burst = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_START;
    in_tdata  <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // bytes with no start, unused command inside
    send_command(CMD_ABSORB, 8'h00);
    send_command(CMD_ABSORB, 8'hff);
    send_command(CMD_UNUSED, 8'ha5);
    send_command(CMD_FINISH, rand_byte());
    // empty messages, with and without start
    send_command(CMD_FINISH, rand_byte());
    send_command(CMD_START, 8'hff);
    send_command(CMD_FINISH, 8'h00);
    send_command(CMD_START, rand_byte());
    send_command(CMD_ABSORB, 8'h61);
    send_command(CMD_ABSORB, 8'h62);
    send_command(CMD_ABSORB, 8'h63);
    send_command(CMD_FINISH, rand_byte());
    // restart drops the partial message
    send_command(CMD_START, rand_byte());
    send_command(CMD_ABSORB, 8'h12);
    send_command(CMD_START, rand_byte());
    send_command(CMD_ABSORB, 8'h7f);
    send_command(CMD_UNUSED, 8'h5a);
    send_command(CMD_FINISH, rand_byte());
    // back-to-back finishes
    send_command(CMD_FINISH, rand_byte());
    send_command(CMD_FINISH, rand_byte());
    wait_digests_out();

    // receiver holds off while several digests queue up behind it
    hold_requests <= hold_requests + 1;
    repeat (3) send_message($urandom_range(0, 6));
    wait_digests_out();

    msg = 0;
    while (items_sent < MIN_ITEMS || digests_asked < MIN_DIGESTS) begin
      send_message((msg < 6) ? boundary_lengths[msg] : pick_length());
      if ($urandom_range(0, 3) == 0) src_burst = !src_burst;
      if (msg % 6 == 5) wait_digests_out();
      msg++;
    end
    wait_digests_out();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sha1_hash_engine test passed");
    end else begin
      $display("sha1_hash_engine test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sha1_pkg.sv
rtl/sha1_ram.sv
rtl/sha1_out.sv
rtl/sha1_hash_engine.sv
rtl/sha1_checker.sv
bench/tb_sha1_hash_engine.sv
